### hw/rtl/sdcfb_pkg.sv
package sdcfb_pkg;

    // Frame layout.
    localparam int unsigned FRAME_LEN    = 6;
    localparam int unsigned CNT_W        = 3;
    localparam logic [CNT_W-1:0] CRC_SLOT = CNT_W'(FRAME_LEN - 1);

    // Fixed bit patterns of the frame.
    localparam logic [7:0] START_BITS = 8'h40;
    localparam logic [6:0] CRC_POLY   = 7'h09;

    // Reset values of the configuration registers.
    localparam logic        HIGH_CAP_RESET   = 1'b0;
    localparam logic [12:0] PAGE_BYTES_RESET = 13'd512;

    // Register indexes on the configuration port.
    localparam logic REG_HIGH_CAPACITY = 1'b0;
    localparam logic REG_PAGE_BYTES    = 1'b1;

    // One byte of CRC7 (x^7 + x^3 + 1), most significant bit first.
    function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] data);
        logic [6:0] crc;
        logic       fb;
        crc = crc_in;
        for (int b = 7; b >= 0; b--)
        begin
            fb  = data[b] ^ crc[6];
            crc = {crc[5:0], 1'b0};
            if (fb)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

### hw/rtl/sd_command_frame_builder.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall   command_index, argument, is_block_address
// output    out        out_valid / out_stall frame_byte, last_byte
// config    in         APB write/read        paddr, pwdata, prdata
//
// Each command word yields six output words, one per cycle while the output is not
// stalled; the byte serializer sets the command rate, but a new command can be taken
// while the previous frame is going out. The first byte passes the input, frame,
// serializer and output registers in turn. A command waits in the input and frame
// registers while the serializer is busy. rst_n clears all valid flags and sets
// the configuration registers to high_capacity = 0 and page_bytes = 512.
module sd_command_frame_builder
    import sdcfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [5:0]  command_index,
    input  logic [31:0] argument,
    input  logic        is_block_address,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic        last_byte,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        high_cap_reg;
    logic [12:0] page_bytes_reg;

    logic        s1_valid_reg;
    logic [5:0]  s1_index_reg;
    logic [31:0] s1_arg_reg;
    logic        s1_scale_reg;

    logic        fr_valid_reg;
    logic [39:0] fr_bytes_reg;

    logic             ser_active_reg;
    logic [39:0]      ser_data_reg;
    logic [CNT_W-1:0] ser_count_reg;
    logic [6:0]       ser_crc_reg;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;

    logic        in_accept;
    logic        s1_advance;
    logic        ser_emit;
    logic        ser_done;
    logic        ser_load;
    logic        cfg_write;
    logic [44:0] product;
    logic [31:0] arg_sent;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_cap_reg   <= HIGH_CAP_RESET;
            page_bytes_reg <= PAGE_BYTES_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_HIGH_CAPACITY: high_cap_reg   <= pwdata[0];
                REG_PAGE_BYTES:    page_bytes_reg <= pwdata[12:0];
                default:           high_cap_reg   <= high_cap_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_HIGH_CAPACITY: prdata = {31'd0, high_cap_reg};
            REG_PAGE_BYTES:    prdata = {19'd0, page_bytes_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // Handshake and stage advance conditions.
    assign ser_emit   = ser_active_reg && (!out_valid_reg || !out_stall);
    assign ser_done   = ser_emit && (ser_count_reg == CRC_SLOT);
    assign ser_load   = fr_valid_reg && (!ser_active_reg || ser_done);
    assign s1_advance = s1_valid_reg && (!fr_valid_reg || ser_load);
    assign in_stall   = s1_valid_reg && !(!fr_valid_reg || ser_load);
    assign in_accept  = in_valid && !in_stall;

    // Input register; the scaling decision is made here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_index_reg <= command_index;
            s1_arg_reg   <= argument;
            s1_scale_reg <= is_block_address && !high_cap_reg;
        end
    end

    // Page to byte address scaling, wrapping at 32 bits.
    assign product  = s1_arg_reg * page_bytes_reg;
    assign arg_sent = s1_scale_reg ? product[31:0] : s1_arg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            fr_valid_reg <= 1'b1;
        end
        else if (ser_load)
        begin
            fr_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            fr_bytes_reg <= {START_BITS | {2'b00, s1_index_reg}, arg_sent};
        end
    end

    // Byte serializer; the CRC is accumulated one byte per emitted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_active_reg <= 1'b0;
        end
        else if (ser_load)
        begin
            ser_active_reg <= 1'b1;
        end
        else if (ser_done)
        begin
            ser_active_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_load)
        begin
            ser_data_reg  <= fr_bytes_reg;
            ser_count_reg <= '0;
            ser_crc_reg   <= '0;
        end
        else if (ser_emit)
        begin
            ser_data_reg  <= {ser_data_reg[31:0], 8'h00};
            ser_count_reg <= ser_count_reg + 1'b1;
            ser_crc_reg   <= crc7_byte(ser_crc_reg, ser_data_reg[39:32]);
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ser_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_emit)
        begin
            out_last_reg <= ser_done;
            out_byte_reg <= ser_done ? {ser_crc_reg, 1'b1} : ser_data_reg[39:32];
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = out_byte_reg;
    assign last_byte  = out_last_reg;

`ifndef SYNTHESIS
    // The byte counter never runs past the CRC slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        ser_active_reg |-> (ser_count_reg <= CRC_SLOT))
        else $error("serializer count out of range");

    // A new frame is loaded only when the previous one has sent its CRC byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ser_load && ser_active_reg) |-> (ser_count_reg == CRC_SLOT))
        else $error("frame loaded over an unfinished frame");

    // The last word of a frame always carries the end bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> out_byte_reg[0])
        else $error("CRC byte without end bit");

    // The input side is stalled only while a command is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled while empty");
`endif

endmodule

### sim/sd_command_frame_builder_tb.sv
`timescale 1ns / 1ps

module sd_command_frame_builder_tb;
    import sdcfb_pkg::*;

    localparam int unsigned IDLE_PERCENT = 11;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HANG_LIMIT = 1000;
    localparam int unsigned ITEMS_PER_PHASE = 55;

    // One expected output word: a frame byte and its end-of-frame marker.
    typedef struct packed
    {
        logic [7:0] value;
        logic       last;
    } frame_word_t;

    // Predicts the frames of accepted commands and checks the output words in order.
    class frame_scoreboard;
        frame_word_t pending[$];
        logic        high_capacity;
        logic [12:0] page_bytes;
        int unsigned errors;

        function new();
            high_capacity = HIGH_CAP_RESET;
            page_bytes    = PAGE_BYTES_RESET;
            errors        = 0;
        endfunction

        function void set_register(logic index, logic [31:0] value);
            if (index == REG_HIGH_CAPACITY)
            begin
                high_capacity = value[0];
            end
            else
            begin
                page_bytes = value[12:0];
            end
        endfunction

        // Builds the six bytes of one command frame and queues them.
        function void note_command(logic [5:0] index, logic [31:0] arg, logic block);
            logic [31:0] sent;
            logic [63:0] product;
            logic [39:0] head;
            logic [6:0]  crc;
            logic        fb;
            frame_word_t w;
            sent = arg;
            // Standard-capacity cards take a byte address, which wraps at 32 bits.
            if (block && !high_capacity)
            begin
                product = 64'(arg) * 64'(page_bytes);
                sent    = product[31:0];
            end
            head = {START_BITS | {2'b00, index}, sent};
            // CRC7 over the first five bytes, most significant bit first.
            crc = '0;
            for (int b = 39; b >= 0; b--)
            begin
                fb  = head[b] ^ crc[6];
                crc = {crc[5:0], 1'b0};
                if (fb)
                begin
                    crc = crc ^ CRC_POLY;
                end
            end
            for (int k = 0; k < 5; k++)
            begin
                w.value = head[39 - 8 * k -: 8];
                w.last  = 1'b0;
                pending.push_back(w);
            end
            w.value = {crc, 1'b1};
            w.last  = 1'b1;
            pending.push_back(w);
        endfunction

        function void check_byte(logic [7:0] value, logic last);
            frame_word_t w;
            if (pending.size() == 0)
            begin
                $error("frame_byte %02h arrived with no frame byte expected", value);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (value !== w.value)
            begin
                $error("frame_byte: expected %02h, got %02h", w.value, value);
                errors++;
            end
            if (last !== w.last)
            begin
                $error("last_byte: expected %0b, got %0b", w.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [5:0]  command_index = '0;
    logic [31:0] argument = '0;
    logic        is_block_address = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    frame_scoreboard frames = new();
    logic            calm = 1'b0;
    int unsigned     hang_cycles = 0;

    sd_command_frame_builder u_top
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command_index    (command_index),
        .argument         (argument),
        .is_block_address (is_block_address),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .frame_byte       (frame_byte),
        .last_byte        (last_byte),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Output side: check each accepted word and stall at random.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                frames.check_byte(frame_byte, last_byte);
            end
            out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        begin
            hang_cycles <= 0;
        end
        else if (hang_cycles >= HANG_LIMIT)
        begin
            $display("FAIL sd_command_frame_builder");
            $finish;
        end
        else
        begin
            hang_cycles <= hang_cycles + 1;
        end
    end

    // Offers one command word and returns at the edge where it is taken.
    task automatic send_command(logic [5:0] index, logic [31:0] arg, logic block);
        if (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid         <= 1'b1;
        command_index    <= index;
        argument         <= arg;
        is_block_address <= block;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        frames.note_command(index, arg, block);
    endtask

    // Waits until every frame byte has come out and the pipeline has settled.
    task automatic drain_frames();
        in_valid <= 1'b0;
        while (frames.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup and access phase of one register write, then one idle cycle on the bus.
    task automatic write_register(logic index, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        frames.set_register(index, value);
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_argument();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 255);
            3: return $urandom_range(0, 32'h000F_FFFF);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(int unsigned count);
        for (int unsigned n = 0; n < count; n++)
        begin
            send_command(6'($urandom_range(0, 63)), pick_argument(),
                         1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: standard card with 512-byte pages.
        send_command(6'd0, 32'h0000_0000, 1'b0);
        send_command(6'd8, 32'h0000_01AA, 1'b0);
        send_command(6'd63, 32'hFFFF_FFFF, 1'b0);
        send_command(6'd17, 32'h0000_0001, 1'b1);
        send_command(6'd24, 32'hAAAA_AAAA, 1'b0);
        send_command(6'd25, 32'h5555_5555, 1'b0);
        // The page times 512 wraps to zero and beyond.
        send_command(6'd18, 32'h0080_0000, 1'b1);
        send_command(6'd32, 32'hFFFF_FFFF, 1'b1);
        send_command(6'd42, 32'h1234_5678, 1'b1);
        send_random(ITEMS_PER_PHASE / 2);
        drain_frames();

        // Largest page size, with no idling on either side.
        calm = 1'b1;
        write_register(REG_PAGE_BYTES, 32'd4096);
        send_command(6'd17, 32'hFFFF_FFFF, 1'b1);
        send_command(6'd17, 32'h0010_0000, 1'b1);
        send_random(ITEMS_PER_PHASE);
        drain_frames();
        calm = 1'b0;

        // Smallest legal page size.
        write_register(REG_PAGE_BYTES, 32'd1);
        send_command(6'd24, 32'hDEAD_BEEF, 1'b1);
        send_random(ITEMS_PER_PHASE);
        drain_frames();

        // High-capacity card: pages go out unscaled.
        write_register(REG_HIGH_CAPACITY, 32'd1);
        write_register(REG_PAGE_BYTES, 32'd512);
        send_command(6'd17, 32'hFFFF_FFFF, 1'b1);
        send_command(6'd55, 32'h0000_0000, 1'b1);
        send_random(ITEMS_PER_PHASE);
        drain_frames();

        // Page size zero, written with stray upper bits: scaled arguments become zero.
        write_register(REG_HIGH_CAPACITY, 32'hFFFF_FFFE);
        write_register(REG_PAGE_BYTES, 32'hFFFF_E000);
        send_command(6'd18, 32'hFFFF_FFFF, 1'b1);
        send_random(ITEMS_PER_PHASE / 2);
        drain_frames();

        // Page size at the top of the register field.
        write_register(REG_PAGE_BYTES, 32'd8191);
        send_random(ITEMS_PER_PHASE / 2);
        drain_frames();

        // A random legal page size.
        write_register(REG_PAGE_BYTES, $urandom_range(1, 4096));
        send_random(ITEMS_PER_PHASE);
        drain_frames();

        repeat (20) @(posedge clk);
        if (frames.errors == 0)
        begin
            $display("PASS sd_command_frame_builder");
        end
        else
        begin
            $display("FAIL sd_command_frame_builder");
        end
        $finish;
    end

endmodule
